@@ rtl/core/torus_point_zbuffer_plotter_defines.svh @@
// Assertion macros used by the plotter RTL.
`ifndef TORUS_POINT_ZBUFFER_PLOTTER_DEFINES_SVH
`define TORUS_POINT_ZBUFFER_PLOTTER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TPZ_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define TPZ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ rtl/core/tpz_pkg.sv @@
// Shared types, codes and the shade table of the torus plotter.
`default_nettype none
package tpz_pkg;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_PLOT  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_SIN_A = 2'd0,
    REG_COS_A = 2'd1,
    REG_SIN_B = 2'd2,
    REG_COS_B = 2'd3
  } reg_idx_t;

  typedef enum logic [4:0] {
    S_SWEEP,
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_SUM,
    S_MUL3,
    S_SUM2,
    S_SCALE,
    S_DIV,
    S_PROJ,
    S_XY,
    S_ADDR,
    S_CMP,
    S_RQ,
    S_RR,
    S_RD,
    S_DONE
  } state_t;

  localparam logic [7:0] CHAR_SPACE   = 8'd32;
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [3:0] SHADE_MAX    = 4'd11;

  // Depth offset 5.0 in Q42.
  localparam logic signed [63:0] DEN_BIAS = 64'sd5 <<< 42;
  // Dividend 1.0 in Q58 for the inverse depth.
  localparam logic [63:0] DIV_ONE = 64'd1 << 58;
  // At or below this denominator, but above zero, the inverse depth saturates.
  localparam logic signed [63:0] DEN_SAT = 64'sd1 <<< 42;
  localparam logic [15:0] DINV_MAX = 16'hFFFF;

  function automatic logic [7:0] shade_char(input logic [3:0] idx);
    logic [7:0] ch;
    begin
      case (idx)
        4'd0:    ch = 8'h2E; // .
        4'd1:    ch = 8'h2C; // ,
        4'd2:    ch = 8'h2D; // -
        4'd3:    ch = 8'h7E; // ~
        4'd4:    ch = 8'h3A; // :
        4'd5:    ch = 8'h3B; // ;
        4'd6:    ch = 8'h3D; // =
        4'd7:    ch = 8'h21; // !
        4'd8:    ch = 8'h2A; // *
        4'd9:    ch = 8'h23; // #
        4'd10:   ch = 8'h24; // $
        default: ch = 8'h40; // @
      endcase
      shade_char = ch;
    end
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/tpz_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module tpz_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/core/torus_point_zbuffer_plotter.sv @@
// Torus point plotter: z-buffered shaded character grid held in two RAMs.
// A plot steps through multiply and sum states, scaling, the bit-serial inverse-depth divider,
// projection, addressing and the z-compare; a read finds the row, then fetches the character.
// One word is in work at a time; a finished result can wait in the output register meanwhile.
// Reset and clear sweep both RAMs with in_stall high, one cell written per cycle.
`default_nettype none
module torus_point_zbuffer_plotter #(
  parameter int COLS = 80,
  parameter int ROWS = 22
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         command,
  input  logic signed [15:0] sin_theta,
  input  logic signed [15:0] cos_theta,
  input  logic signed [15:0] sin_phi,
  input  logic signed [15:0] cos_phi,
  input  logic [10:0]        print_position,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               drawn,
  output logic [10:0]        cell_written,
  output logic [7:0]         char_code,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

`include "torus_point_zbuffer_plotter_defines.svh"

  localparam int CELLS = COLS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int RECIP = (2 ** 20 + COLS - 1) / COLS;
  localparam logic signed [63:0] X_BIAS = 64'(COLS / 2) <<< 44;
  localparam logic signed [63:0] Y_BIAS = 64'(ROWS / 2 + 1) <<< 44;
  localparam logic signed [63:0] Q44_ROUND = (64'sd1 <<< 44) - 64'sd1;
  localparam logic signed [63:0] Q28_ROUND = (64'sd1 <<< 28) - 64'sd1;

  tpz_pkg::state_t state, state_next;

  logic signed [15:0] sin_a, cos_a, sin_b, cos_b;
  tpz_pkg::cmd_t      cmd_in;
  logic               clear_cmd;
  logic [AW-1:0]      sweep_cnt;

  logic signed [15:0] c_r, l_r, f_r, d_r;
  logic [10:0]        pos_r;
  logic signed [16:0] h;

  logic signed [32:0] ch, lh;
  logic signed [31:0] fe, fg, cd, ld;
  logic signed [48:0] che, chg, lhm, lhn;
  logic signed [47:0] cdg, cde, ldn;
  logic signed [63:0] den, lum_rest;
  logic signed [49:0] t, a_r;
  logic signed [63:0] tn, tm, am;
  logic signed [63:0] u, v, lum;
  logic signed [35:0] up, vp;
  logic [3:0]         shade;
  logic [9:0]         lum_int;

  logic [63:0]        rem, dsh;
  logic [15:0]        quo;
  logic [3:0]         div_cnt;
  logic               div_bit;
  logic [15:0]        dinv_c, dinv;

  logic signed [52:0] du, dv;
  logic signed [63:0] sx, sy, sxa, sya;
  logic signed [19:0] x, y;
  logic               in_grid, in_grid_r;
  logic [AW-1:0]      cell_c, cell_r;
  logic               win;

  logic [10:0]        rq;
  logic               nl;

  logic               res_drawn;
  logic [10:0]        res_cell;
  logic [7:0]         res_char;
  logic               out_free;

  logic               depth_we, char_we;
  logic [AW-1:0]      wr_addr, depth_raddr, char_raddr;
  logic [15:0]        depth_wdata, depth_rdata;
  logic [7:0]         char_wdata, char_rdata;

  assign cmd_in   = tpz_pkg::cmd_t'(command);
  assign h        = 17'(d_r) + 17'sd32768;
  assign out_free = !out_valid || !out_stall;
  assign div_bit  = rem >= dsh;
  assign lum_int  = lum[62:53];

  // Inverse depth: zero behind the eye, saturated for very near points.
  assign dinv_c = (den <= 64'sd0) ? 16'd0 :
                  (den <= tpz_pkg::DEN_SAT) ? tpz_pkg::DINV_MAX : quo;

  assign sx  = X_BIAS + (64'(du) <<< 5) - (64'(du) <<< 1);
  assign sy  = Y_BIAS + (64'(dv) <<< 4) - 64'(dv);
  assign sxa = sx + (sx[63] ? Q44_ROUND : 64'sd0);
  assign sya = sy + (sy[63] ? Q44_ROUND : 64'sd0);

  assign in_grid = !x[19] && (x != 20'sd0) && (x[18:0] < 19'(COLS)) &&
                   !y[19] && (y != 20'sd0) && (y[18:0] < 19'(ROWS));
  assign cell_c  = AW'(x[18:0]) + AW'(COLS) * AW'(y[18:0]);
  assign win     = in_grid_r && (dinv > depth_rdata);

  tpz_ram #(.WIDTH(16), .DEPTH(CELLS)) u_depth_ram (
    .clk   (clk),
    .we    (depth_we),
    .waddr (wr_addr),
    .wdata (depth_wdata),
    .raddr (depth_raddr),
    .rdata (depth_rdata)
  );

  tpz_ram #(.WIDTH(8), .DEPTH(CELLS)) u_char_ram (
    .clk   (clk),
    .we    (char_we),
    .waddr (wr_addr),
    .wdata (char_wdata),
    .raddr (char_raddr),
    .rdata (char_rdata)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      tpz_pkg::S_SWEEP: begin
        if (sweep_cnt == AW'(CELLS - 1)) begin
          state_next = clear_cmd ? tpz_pkg::S_DONE : tpz_pkg::S_IDLE;
        end
      end
      tpz_pkg::S_IDLE: begin
        if (in_valid) begin
          case (cmd_in)
            tpz_pkg::CMD_CLEAR: state_next = tpz_pkg::S_SWEEP;
            tpz_pkg::CMD_PLOT:  state_next = tpz_pkg::S_MUL1;
            tpz_pkg::CMD_READ:  state_next = tpz_pkg::S_RQ;
            default:            state_next = tpz_pkg::S_DONE;
          endcase
        end
      end
      tpz_pkg::S_MUL1:  state_next = tpz_pkg::S_MUL2;
      tpz_pkg::S_MUL2:  state_next = tpz_pkg::S_SUM;
      tpz_pkg::S_SUM:   state_next = tpz_pkg::S_MUL3;
      tpz_pkg::S_MUL3:  state_next = tpz_pkg::S_SUM2;
      tpz_pkg::S_SUM2:  state_next = tpz_pkg::S_SCALE;
      tpz_pkg::S_SCALE: state_next = tpz_pkg::S_DIV;
      tpz_pkg::S_DIV: begin
        if (div_cnt == 4'd0) begin
          state_next = tpz_pkg::S_PROJ;
        end
      end
      tpz_pkg::S_PROJ:  state_next = tpz_pkg::S_XY;
      tpz_pkg::S_XY:    state_next = tpz_pkg::S_ADDR;
      tpz_pkg::S_ADDR:  state_next = tpz_pkg::S_CMP;
      tpz_pkg::S_CMP:   state_next = tpz_pkg::S_DONE;
      tpz_pkg::S_RQ:    state_next = tpz_pkg::S_RR;
      tpz_pkg::S_RR:    state_next = tpz_pkg::S_RD;
      tpz_pkg::S_RD:    state_next = tpz_pkg::S_DONE;
      tpz_pkg::S_DONE: begin
        if (out_free) begin
          state_next = tpz_pkg::S_IDLE;
        end
      end
      default:          state_next = tpz_pkg::S_IDLE;
    endcase
  end

  // Memory controls and input handshake.
  always_comb begin
    in_stall    = 1'b1;
    depth_we    = 1'b0;
    char_we     = 1'b0;
    wr_addr     = cell_r;
    depth_wdata = dinv;
    char_wdata  = tpz_pkg::shade_char(shade);
    depth_raddr = cell_c;
    char_raddr  = AW'(pos_r);
    case (state)
      tpz_pkg::S_IDLE: in_stall = 1'b0;
      tpz_pkg::S_SWEEP: begin
        depth_we    = 1'b1;
        char_we     = 1'b1;
        wr_addr     = sweep_cnt;
        depth_wdata = 16'd0;
        char_wdata  = tpz_pkg::CHAR_SPACE;
      end
      tpz_pkg::S_CMP: begin
        depth_we = win;
        char_we  = win;
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tpz_pkg::S_SWEEP;
      sweep_cnt <= '0;
      clear_cmd <= 1'b0;
      out_valid <= 1'b0;
      sin_a     <= 16'sd0;
      cos_a     <= 16'sd16384;
      sin_b     <= 16'sd0;
      cos_b     <= 16'sd16384;
    end else begin
      state <= state_next;
      if (state == tpz_pkg::S_SWEEP) begin
        sweep_cnt <= (sweep_cnt == AW'(CELLS - 1)) ? '0 : sweep_cnt + AW'(1);
      end
      if (state == tpz_pkg::S_IDLE && in_valid) begin
        clear_cmd <= (cmd_in == tpz_pkg::CMD_CLEAR);
      end
      if (state == tpz_pkg::S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (tpz_pkg::reg_idx_t'(cfg_index))
          tpz_pkg::REG_SIN_A: sin_a <= cfg_data;
          tpz_pkg::REG_COS_A: cos_a <= cfg_data;
          tpz_pkg::REG_SIN_B: sin_b <= cfg_data;
          tpz_pkg::REG_COS_B: cos_b <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state == tpz_pkg::S_DONE && out_free) begin
      drawn        <= res_drawn;
      cell_written <= res_cell;
      char_code    <= res_char;
    end
    case (state)
      tpz_pkg::S_IDLE: begin
        c_r       <= sin_theta;
        l_r       <= cos_theta;
        f_r       <= sin_phi;
        d_r       <= cos_phi;
        pos_r     <= print_position;
        res_drawn <= 1'b0;
        res_cell  <= 11'd0;
        res_char  <= 8'd0;
      end
      tpz_pkg::S_MUL1: begin
        ch <= 33'(c_r) * 33'(h);
        lh <= 33'(l_r) * 33'(h);
        fe <= 32'(f_r) * 32'(sin_a);
        fg <= 32'(f_r) * 32'(cos_a);
        cd <= 32'(c_r) * 32'(d_r);
        ld <= 32'(l_r) * 32'(d_r);
      end
      tpz_pkg::S_MUL2: begin
        che <= 49'(ch) * 49'(sin_a);
        chg <= 49'(ch) * 49'(cos_a);
        lhm <= 49'(lh) * 49'(cos_b);
        lhn <= 49'(lh) * 49'(sin_b);
        cdg <= 48'(cd) * 48'(cos_a);
        cde <= 48'(cd) * 48'(sin_a);
        ldn <= 48'(ld) * 48'(sin_b);
      end
      tpz_pkg::S_SUM: begin
        den      <= 64'(che) + (64'(fg) <<< 14) + tpz_pkg::DEN_BIAS;
        t        <= 50'(chg) - (50'(fe) <<< 14);
        a_r      <= (50'(fe) <<< 14) - 50'(cdg);
        lum_rest <= -(64'(cde) <<< 14) - (64'(fg) <<< 28) - (64'(ldn) <<< 14);
      end
      tpz_pkg::S_MUL3: begin
        tn <= 64'(t) * 64'(sin_b);
        tm <= 64'(t) * 64'(cos_b);
        am <= 64'(a_r) * 64'(cos_b);
      end
      tpz_pkg::S_SUM2: begin
        u   <= (64'(lhm) <<< 14) - tn;
        v   <= (64'(lhn) <<< 14) + tm;
        lum <= am + lum_rest;
      end
      tpz_pkg::S_SCALE: begin
        // Shifts truncate toward zero: negative values get a bias first.
        up      <= 36'((u + (u[63] ? Q28_ROUND : 64'sd0)) >>> 28);
        vp      <= 36'((v + (v[63] ? Q28_ROUND : 64'sd0)) >>> 28);
        shade   <= lum[63] ? 4'd0 :
                   (lum_int > 10'(tpz_pkg::SHADE_MAX)) ? tpz_pkg::SHADE_MAX : lum_int[3:0];
        rem     <= tpz_pkg::DIV_ONE;
        dsh     <= 64'(den) << 15;
        quo     <= 16'd0;
        div_cnt <= 4'd15;
      end
      tpz_pkg::S_DIV: begin
        if (div_bit) begin
          rem <= rem - dsh;
        end
        quo     <= {quo[14:0], div_bit};
        dsh     <= dsh >> 1;
        div_cnt <= div_cnt - 4'd1;
      end
      tpz_pkg::S_PROJ: begin
        dinv <= dinv_c;
        du   <= 53'($signed({1'b0, dinv_c})) * 53'(up);
        dv   <= 53'($signed({1'b0, dinv_c})) * 53'(vp);
      end
      tpz_pkg::S_XY: begin
        x <= 20'(sxa >>> 44);
        y <= 20'(sya >>> 44);
      end
      tpz_pkg::S_ADDR: begin
        cell_r    <= cell_c;
        in_grid_r <= in_grid;
      end
      tpz_pkg::S_CMP: begin
        res_drawn <= win;
        res_cell  <= win ? 11'(cell_r) : 11'd0;
        res_char  <= win ? tpz_pkg::shade_char(shade) : 8'd0;
      end
      tpz_pkg::S_RQ: begin
        rq <= 11'((28'(pos_r) * 28'(RECIP)) >> 20);
      end
      tpz_pkg::S_RR: begin
        nl <= (20'(pos_r) == 20'(rq) * 20'(COLS));
      end
      tpz_pkg::S_RD: begin
        if (nl) begin
          res_char <= tpz_pkg::CHAR_NEWLINE;
        end else if (16'(pos_r) < 16'(CELLS)) begin
          res_char <= char_rdata;
        end else begin
          res_char <= tpz_pkg::CHAR_SPACE;
        end
      end
      default: begin
      end
    endcase
  end

  `TPZ_ASSERT_IMP(a_drawn_is_shade, out_valid && drawn, char_code != tpz_pkg::CHAR_SPACE && char_code != tpz_pkg::CHAR_NEWLINE && cell_written != 11'd0)
  `TPZ_ASSERT_NEXT(a_accept_leaves_idle, in_valid && !in_stall, state != tpz_pkg::S_IDLE)
  `TPZ_ASSERT_NEXT(a_div_ends, state == tpz_pkg::S_DIV && div_cnt == 4'd0, state == tpz_pkg::S_PROJ)

endmodule
`default_nettype wire

@@ tb/torus_point_zbuffer_plotter_tb.sv @@
// Self-checking testbench for the torus point plotter: predicted plots, clears and reads.
`default_nettype none
module torus_point_zbuffer_plotter_tb;

  localparam int COLS = 80;
  localparam int ROWS = 22;
  localparam int CELLS = COLS * ROWS;
  localparam int WATCHDOG_LIMIT = 200000;

  typedef struct packed {
    logic        drawn;
    logic [10:0] cell_idx;
    logic [7:0]  ch;
  } plot_result_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [1:0] command;
  logic signed [15:0] sin_theta, cos_theta, sin_phi, cos_phi;
  logic [10:0] print_position;
  logic out_valid;
  logic out_stall;
  logic drawn;
  logic [10:0] cell_written;
  logic [7:0] char_code;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;

  torus_point_zbuffer_plotter #(.COLS(COLS), .ROWS(ROWS)) i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .command(command),
    .sin_theta(sin_theta), .cos_theta(cos_theta), .sin_phi(sin_phi), .cos_phi(cos_phi),
    .print_position(print_position),
    .out_valid(out_valid), .out_stall(out_stall),
    .drawn(drawn), .cell_written(cell_written), .char_code(char_code),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state: frame rotation and both stores.
  longint rot_sin_a, rot_cos_a, rot_sin_b, rot_cos_b;
  logic [15:0] depth_mirror [CELLS];
  logic [7:0] char_mirror [CELLS];
  plot_result_t expected_results[$];

  int send_idle_pct;
  int recv_stall_pct;
  int failures;
  int words_sent;
  int words_checked;
  int plots_drawn;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] shade_of(input longint idx);
    string shades;
    shades = ".,-~:;=!*#$@";
    return shades[idx];
  endfunction

  function automatic void clear_mirror();
    for (int i = 0; i < CELLS; i++) begin
      depth_mirror[i] = '0;
      char_mirror[i] = tpz_pkg::CHAR_SPACE;
    end
  endfunction

  function automatic plot_result_t predict_plot(input longint c, input longint l,
                                                input longint f, input longint d);
    plot_result_t r;
    longint e, g, n, m, h, den, dinv, t, u, v, x, y, lum, shade, cell_idx;
    logic [63:0] q;
    e = rot_sin_a; g = rot_cos_a; n = rot_sin_b; m = rot_cos_b;
    r = '0;
    h = d + 32768;
    den = c * h * e + f * g * 16384 + (64'sd5 <<< 42);
    dinv = 0;
    if (den > 0) begin
      q = (64'd1 << 58) / den;
      dinv = (q > 65535) ? 65535 : longint'(q);
    end
    t = c * h * g - f * e * 16384;
    u = (l * h * m * 16384 - t * n) / (64'sd1 <<< 28);
    v = (l * h * n * 16384 + t * m) / (64'sd1 <<< 28);
    x = ((COLS / 2) * (64'sd1 <<< 44) + 30 * dinv * u) / (64'sd1 <<< 44);
    y = ((ROWS / 2 + 1) * (64'sd1 <<< 44) + 15 * dinv * v) / (64'sd1 <<< 44);
    lum = (f * e * 16384 - c * d * g) * m - c * d * e * 16384
          - f * g * (64'sd1 <<< 28) - l * d * n * 16384;
    shade = lum / (64'sd1 <<< 53);
    if (shade < 0) shade = 0;
    if (shade > tpz_pkg::SHADE_MAX) shade = tpz_pkg::SHADE_MAX;
    if (y > 0 && y < ROWS && x > 0 && x < COLS) begin
      cell_idx = x + COLS * y;
      if (dinv > depth_mirror[cell_idx]) begin
        depth_mirror[cell_idx] = dinv[15:0];
        char_mirror[cell_idx] = shade_of(shade);
        r.drawn = 1'b1;
        r.cell_idx = cell_idx[10:0];
        r.ch = char_mirror[cell_idx];
      end
    end
    return r;
  endfunction

  // Sends one word and queues its expected result once it is accepted.
  // Valid stays high after the accept until the next word or an idle cycle replaces it.
  task automatic send_word(input tpz_pkg::cmd_t cmd, input logic [15:0] st,
                           input logic [15:0] ct, input logic [15:0] sp,
                           input logic [15:0] cp, input logic [10:0] pos);
    plot_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    sin_theta <= st; cos_theta <= ct; sin_phi <= sp; cos_phi <= cp;
    print_position <= pos;
    do @(posedge clk); while (in_stall);
    r = '0;
    case (cmd)
      tpz_pkg::CMD_CLEAR: clear_mirror();
      tpz_pkg::CMD_PLOT: begin
        r = predict_plot(longint'($signed(st)), longint'($signed(ct)),
                         longint'($signed(sp)), longint'($signed(cp)));
        if (r.drawn) plots_drawn++;
      end
      tpz_pkg::CMD_READ: begin
        if (pos % COLS == 0) r.ch = tpz_pkg::CHAR_NEWLINE;
        else if (pos < CELLS) r.ch = char_mirror[pos];
        else r.ch = tpz_pkg::CHAR_SPACE;
      end
      default: ;
    endcase
    expected_results.push_back(r);
    words_sent++;
  endtask

  // The block is idle once every result is back; extra cycles cover a late no-op.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_rotation(input tpz_pkg::reg_idx_t idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      tpz_pkg::REG_SIN_A: rot_sin_a = longint'($signed(val));
      tpz_pkg::REG_COS_A: rot_cos_a = longint'($signed(val));
      tpz_pkg::REG_SIN_B: rot_sin_b = longint'($signed(val));
      default:            rot_cos_b = longint'($signed(val));
    endcase
  endtask

  task automatic set_frame_angle(input real a, input real b);
    write_rotation(tpz_pkg::REG_SIN_A, 16'($rtoi($sin(a) * 16384.0)));
    write_rotation(tpz_pkg::REG_COS_A, 16'($rtoi($cos(a) * 16384.0)));
    write_rotation(tpz_pkg::REG_SIN_B, 16'($rtoi($sin(b) * 16384.0)));
    write_rotation(tpz_pkg::REG_COS_B, 16'($rtoi($cos(b) * 16384.0)));
  endtask

  function automatic logic [15:0] rand_trig();
    return 16'($signed($urandom_range(32768)) - 16384);
  endfunction

  task automatic plot_angles(input real th, input real ph);
    send_word(tpz_pkg::CMD_PLOT, 16'($rtoi($sin(th) * 16384.0)),
              16'($rtoi($cos(th) * 16384.0)),
              16'($rtoi($sin(ph) * 16384.0)), 16'($rtoi($cos(ph) * 16384.0)),
              11'($urandom));
  endtask

  task automatic test_directed();
    send_word(tpz_pkg::CMD_READ, 0, 0, 0, 0, 11'd0);
    send_word(tpz_pkg::CMD_READ, 0, 0, 0, 0, 11'd1);
    send_word(tpz_pkg::CMD_READ, 0, 0, 0, 0, 11'd1759);
    send_word(tpz_pkg::CMD_READ, 0, 0, 0, 0, 11'd1761);
    send_word(tpz_pkg::CMD_READ, 0, 0, 0, 0, 11'd2047);
    send_word(tpz_pkg::CMD_PLOT, 16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384, 0);
    send_word(tpz_pkg::CMD_PLOT, -16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384, 0);
    send_word(tpz_pkg::CMD_PLOT, 0, 16'sd16384, 0, 16'sd16384, 0);
    send_word(tpz_pkg::CMD_PLOT, 0, 16'sd16384, 0, 16'sd16384, 0);
    send_word(tpz_pkg::CMD_PLOT, 0, -16'sd16384, 16'sd16384, 0, 0);
    // Out-of-range values drive luminance saturation and the eye-plane cases.
    send_word(tpz_pkg::CMD_PLOT, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 0);
    send_word(tpz_pkg::CMD_PLOT, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 0);
    send_word(tpz_pkg::CMD_PLOT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
    send_word(tpz_pkg::CMD_NOP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 11'h7FF);
    send_word(tpz_pkg::CMD_READ, 0, 0, 0, 0, 11'd120);
    send_word(tpz_pkg::CMD_READ, 0, 0, 0, 0, 11'd80);
    send_word(tpz_pkg::CMD_CLEAR, 0, 0, 0, 0, 0);
    send_word(tpz_pkg::CMD_READ, 0, 0, 0, 0, 11'd121);
    drain();
  endtask

  task automatic test_extreme_rotations();
    write_rotation(tpz_pkg::REG_SIN_A, 16'sd16384);
    write_rotation(tpz_pkg::REG_COS_A, -16'sd16384);
    write_rotation(tpz_pkg::REG_SIN_B, -16'sd16384);
    write_rotation(tpz_pkg::REG_COS_B, 16'sd16384);
    repeat (20) send_word(tpz_pkg::CMD_PLOT, rand_trig(), rand_trig(), rand_trig(),
                          rand_trig(), 0);
    drain();
    write_rotation(tpz_pkg::REG_SIN_A, 16'h8000);
    write_rotation(tpz_pkg::REG_COS_A, 16'h7FFF);
    repeat (10) send_word(tpz_pkg::CMD_PLOT, 16'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom), 0);
    drain();
  endtask

  // Clears and renders a torus frame at a random angle, mixing in reads and no-ops, then reads part of the grid back.
  task automatic test_frame(input int n_points);
    set_frame_angle($urandom_range(6283) / 1000.0, $urandom_range(6283) / 1000.0);
    send_word(tpz_pkg::CMD_CLEAR, 0, 0, 0, 0, 0);
    for (int i = 0; i < n_points; i++) begin
      case ($urandom_range(9))
        0: send_word(tpz_pkg::CMD_PLOT, rand_trig(), rand_trig(), rand_trig(),
                     rand_trig(), 0);
        1: send_word(tpz_pkg::CMD_READ, 0, 0, 0, 0, 11'($urandom));
        2: send_word(tpz_pkg::CMD_NOP, 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom), 11'($urandom));
        default: plot_angles($urandom_range(6283) / 1000.0, $urandom_range(6283) / 1000.0);
      endcase
    end
    repeat (40) send_word(tpz_pkg::CMD_READ, 0, 0, 0, 0, 11'($urandom_range(1760)));
    drain();
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int k = 0; k < 3; k++) test_frame(35 + $urandom_range(40));
  endtask

  // Receiver stall and result checking.
  always @(posedge clk) begin
    plot_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        words_checked++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected word drawn=%0d cell=%0d char=%0d",
                   $time, drawn, cell_written, char_code);
          failures++;
        end else begin
          want = expected_results.pop_front();
          if (drawn !== want.drawn || cell_written !== want.cell_idx ||
              char_code !== want.ch) begin
            $display("%0t: mismatch expected drawn=%0d cell=%0d char=%0d, got %0d %0d %0d",
                     $time, want.drawn, want.cell_idx, want.ch, drawn, cell_written,
                     char_code);
            failures++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog on accepted words and taken results; covers the clearing sweep after reset.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("torus_point_zbuffer_plotter_tb: FAIL");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    command = tpz_pkg::CMD_NOP;
    sin_theta = 0; cos_theta = 0; sin_phi = 0; cos_phi = 0;
    print_position = 0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = tpz_pkg::REG_SIN_A;
    cfg_data = 0;
    failures = 0; words_sent = 0; words_checked = 0; plots_drawn = 0; idle_cycles = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    rot_sin_a = 0; rot_cos_a = 16384; rot_sin_b = 0; rot_cos_b = 16384;
    clear_mirror();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_extreme_rotations();
    run_phase(22, 83);
    run_phase(83, 22);
    run_phase(0, 0);
    drain();
    $display("Covered %0d words and %0d results, %0d plots drawn,", words_sent,
             words_checked, plots_drawn);
    $display("over extreme and random frame rotations with clears and read-back.");
    if (failures == 0) begin
      $display("torus_point_zbuffer_plotter_tb: PASS");
    end else begin
      $display("torus_point_zbuffer_plotter_tb: FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ sim.f @@
+incdir+rtl/core
rtl/core/tpz_pkg.sv
rtl/core/tpz_ram.sv
rtl/core/torus_point_zbuffer_plotter.sv
tb/torus_point_zbuffer_plotter_tb.sv
